[rtl/core/lcpt_pkg.sv]
// Lazy-commit page tracker: shared types, codes and helper functions.
// Used by the channel interfaces, the run finder and the core top level.
`default_nettype none

package lcpt_pkg;

  localparam int TRACKED_PAGES_DEF = 4096;
  localparam int MAX_RANGE_PAGES   = 32;
  localparam int WORD_BITS         = 32;

  typedef enum logic [2:0] {
    MODE_COMMIT           = 3'd0,
    MODE_MARK_LAZY        = 3'd1,
    MODE_COMMIT_LAZY      = 3'd2,
    MODE_UNCOMMIT         = 3'd3,
    MODE_UNCOMMIT_REALLOC = 3'd4,
    MODE_REPROTECT        = 3'd5,
    MODE_READ_SLICE       = 3'd6,
    MODE_NOP              = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_SLICE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PERM   = 2'd2
  } action_t;

  localparam logic CFG_REGION_BASE  = 1'b0;
  localparam logic CFG_REGION_PAGES = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_RD0,
    ST_RD1,
    ST_LOAD,
    ST_EXEC,
    ST_SCAN,
    ST_WB0,
    ST_WB1,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [35:0] first_page;
    logic [5:0]  num_pages;
    logic [2:0]  prot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  run_action;
    logic [35:0] run_start_page;
    logic [5:0]  run_count;
    logic [2:0]  run_prot;
    logic [31:0] slice_bits;
    logic        status;
    logic        last;
  } res_t;

  // One segment of equal bits starting at the scan position.
  typedef struct packed {
    logic        cur;
    logic [5:0]  end_pos;
    logic [5:0]  len;
    logic [31:0] seg;
  } run_info_t;

  // Ones in bit positions below n, n in 0..32.
  function automatic logic [31:0] lt_mask(input logic [5:0] n);
    logic [31:0] m;
    m = (n >= 6'd32) ? '1 : ((32'd1 << n[4:0]) - 32'd1);
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lcpt_if.sv]
// Lazy-commit page tracker: valid/ready channel interfaces for commands and results.
// Depends on lcpt_pkg for the payload structs.
`default_nettype none

interface lcpt_cmd_if;
  logic          valid;
  logic          ready;
  lcpt_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lcpt_res_if;
  logic          valid;
  logic          ready;
  lcpt_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lazy_commit_page_tracker_core.sv]
// Lazy-commit page tracker top level: command FSM, bitmap RAM, result register.
// Depends on lcpt_pkg, lcpt_if, lcpt_ram and lcpt_run_find.
//
//   channel   dir   handshake          payload
//   in_cmd    in    valid/ready        mode, first_page, num_pages, prot
//   out_res   out   valid/ready        kind, run_*, slice_bits, status, last
//   cfg_*     in    cfg_we             cfg_index selects register, cfg_wdata
//
// A scanning command steps through check, two reads, load, exec, a scan step per bit
// segment of the range (up to 32), a write-back (two if it spans two bitmap words)
// and done; mark lazy skips the scan, read slice and mode 7 go from exec to done, a
// range error from check to done. The single-port bitmap RAM serializes the reads
// and write-backs. After reset a clearing pass zeroes the bitmap word by word, with
// no command taken. A stalled result register holds the read-slice, scan or done step.
`default_nettype none

module lazy_commit_page_tracker_core #(
  parameter int TRACKED_PAGES = lcpt_pkg::TRACKED_PAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  lcpt_cmd_if.sink          in_cmd,
  lcpt_res_if.source        out_res,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [35:0]  cfg_wdata
);

  localparam int WORDS = (TRACKED_PAGES + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW    = AW + 5;

  lcpt_pkg::state_t state_r, state_nxt;

  logic [35:0]  base_r;
  logic [12:0]  region_pages_r;

  logic [2:0]   mode_r;
  logic [35:0]  sp_r;
  logic [5:0]   cnt_r;
  logic [2:0]   prot_r;

  logic [OW-1:0] first_r, first_nxt;
  logic          need_w1_r, need_w1_nxt;
  logic          status_r, status_nxt;
  logic [31:0]   w0_r, w0_nxt;
  logic [31:0]   w1_r, w1_nxt;
  logic [31:0]   win_r, win_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  lcpt_pkg::res_t out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  lcpt_pkg::run_info_t run;

  // Combinational helpers
  logic [35:0]   offset;
  logic [36:0]   end_sum;
  logic [36:0]   lim;
  logic          range_ok;
  logic [6:0]    span;
  logic          out_free;
  logic          want;
  logic [31:0]   cnt_mask;
  logic [AW-1:0] word0;
  logic [AW-1:0] word1;
  logic [63:0]   pair_ld;
  logic [63:0]   pair_mask;
  logic [63:0]   pair_wb;
  logic          scan_end;
  logic          run_hit;
  logic [1:0]    run_act;

  lcpt_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lcpt_run_find u_find (
    .win  (win_r),
    .pos  (pos_r),
    .cnt  (cnt_r),
    .info (run)
  );

  assign in_cmd.ready  = (state_r == lcpt_pkg::ST_IDLE);
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;
  assign out_free      = !out_valid_r || out_res.ready;

  always_comb begin
    offset   = sp_r - base_r;
    end_sum  = {1'b0, offset} + 37'(cnt_r);
    lim      = (37'(region_pages_r) > 37'(TRACKED_PAGES)) ? 37'(TRACKED_PAGES)
                                                          : 37'(region_pages_r);
    range_ok = (cnt_r <= 6'(lcpt_pkg::MAX_RANGE_PAGES)) && (sp_r >= base_r) &&
               (end_sum <= lim);
    span     = 7'(offset[4:0]) + 7'(cnt_r);
    cnt_mask = lcpt_pkg::lt_mask(cnt_r);
    want     = (mode_r == lcpt_pkg::MODE_COMMIT_LAZY);
    word0    = first_r[OW-1:5];
    // Second word only matters when the range crosses a word boundary.
    word1    = need_w1_r ? (word0 + AW'(1)) : word0;
    pair_ld  = {(need_w1_r ? mem_rdata : 32'd0), w0_r};
    pair_mask = {32'd0, cnt_mask} << first_r[4:0];
    pair_wb  = ({w1_r, w0_r} & ~pair_mask) |
               ({32'd0, win_r & cnt_mask} << first_r[4:0]);
    scan_end = (pos_r >= cnt_r);
    run_hit  = (run.cur == want);
    case (mode_r)
      lcpt_pkg::MODE_COMMIT,
      lcpt_pkg::MODE_COMMIT_LAZY: run_act = lcpt_pkg::ACT_ADD;
      lcpt_pkg::MODE_REPROTECT:   run_act = lcpt_pkg::ACT_PERM;
      default:                    run_act = lcpt_pkg::ACT_REMOVE;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcpt_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(WORDS - 1)) state_nxt = lcpt_pkg::ST_IDLE;
      end
      lcpt_pkg::ST_IDLE: begin
        if (in_cmd.valid) state_nxt = lcpt_pkg::ST_CHECK;
      end
      lcpt_pkg::ST_CHECK: begin
        state_nxt = range_ok ? lcpt_pkg::ST_RD0 : lcpt_pkg::ST_DONE;
      end
      lcpt_pkg::ST_RD0:  state_nxt = lcpt_pkg::ST_RD1;
      lcpt_pkg::ST_RD1:  state_nxt = lcpt_pkg::ST_LOAD;
      lcpt_pkg::ST_LOAD: state_nxt = lcpt_pkg::ST_EXEC;
      lcpt_pkg::ST_EXEC: begin
        case (mode_r)
          lcpt_pkg::MODE_MARK_LAZY: state_nxt = lcpt_pkg::ST_WB0;
          lcpt_pkg::MODE_READ_SLICE: begin
            if (out_free) state_nxt = lcpt_pkg::ST_DONE;
          end
          lcpt_pkg::MODE_NOP: state_nxt = lcpt_pkg::ST_DONE;
          default:            state_nxt = lcpt_pkg::ST_SCAN;
        endcase
      end
      lcpt_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = lcpt_pkg::ST_WB0;
      end
      lcpt_pkg::ST_WB0: begin
        state_nxt = need_w1_r ? lcpt_pkg::ST_WB1 : lcpt_pkg::ST_DONE;
      end
      lcpt_pkg::ST_WB1: state_nxt = lcpt_pkg::ST_DONE;
      lcpt_pkg::ST_DONE: begin
        if (out_free) state_nxt = lcpt_pkg::ST_IDLE;
      end
      default: state_nxt = lcpt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    first_nxt     = first_r;
    need_w1_nxt   = need_w1_r;
    status_nxt    = status_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    win_nxt       = win_r;
    pos_nxt       = pos_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_res.ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = word0;
    mem_wdata     = pair_wb[31:0];

    case (state_r)
      lcpt_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = 32'd0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      lcpt_pkg::ST_CHECK: begin
        first_nxt   = offset[OW-1:0];
        need_w1_nxt = (span > 7'd32);
        status_nxt  = !range_ok;
        pos_nxt     = 6'd0;
      end
      lcpt_pkg::ST_RD0: begin
        mem_addr = word0;
      end
      lcpt_pkg::ST_RD1: begin
        mem_addr = word1;
        w0_nxt   = mem_rdata;
      end
      lcpt_pkg::ST_LOAD: begin
        w1_nxt  = pair_ld[63:32];
        win_nxt = 32'(pair_ld >> first_r[4:0]) & cnt_mask;
      end
      lcpt_pkg::ST_EXEC: begin
        case (mode_r)
          lcpt_pkg::MODE_MARK_LAZY: win_nxt = win_r | cnt_mask;
          lcpt_pkg::MODE_READ_SLICE: begin
            if (out_free) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt            = '0;
              out_data_nxt.kind       = lcpt_pkg::KIND_SLICE;
              out_data_nxt.slice_bits = win_r;
            end
          end
          default: ;
        endcase
      end
      lcpt_pkg::ST_SCAN: begin
        if (!scan_end) begin
          if (run_hit) begin
            // Emit one run, then apply the mode's update to its pages.
            if (out_free) begin
              out_valid_nxt               = 1'b1;
              out_data_nxt                = '0;
              out_data_nxt.kind           = lcpt_pkg::KIND_RUN;
              out_data_nxt.run_action     = run_act;
              out_data_nxt.run_start_page = sp_r + 36'(pos_r);
              out_data_nxt.run_count      = run.len;
              out_data_nxt.run_prot       = (run_act == lcpt_pkg::ACT_REMOVE) ? 3'd0
                                                                              : prot_r;
              pos_nxt = run.end_pos;
              case (mode_r)
                lcpt_pkg::MODE_COMMIT_LAZY,
                lcpt_pkg::MODE_UNCOMMIT:         win_nxt = win_r & ~run.seg;
                lcpt_pkg::MODE_UNCOMMIT_REALLOC: win_nxt = win_r | run.seg;
                default: ;
              endcase
            end
          end else begin
            // Skip the segment; uncommit drops lazy bits silently.
            pos_nxt = run.end_pos;
            if (mode_r == lcpt_pkg::MODE_UNCOMMIT) win_nxt = win_r & ~run.seg;
          end
        end
      end
      lcpt_pkg::ST_WB0: begin
        mem_we    = 1'b1;
        mem_addr  = word0;
        mem_wdata = pair_wb[31:0];
      end
      lcpt_pkg::ST_WB1: begin
        mem_we    = 1'b1;
        mem_addr  = word1;
        mem_wdata = pair_wb[63:32];
      end
      lcpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt        = '0;
          out_data_nxt.kind   = lcpt_pkg::KIND_DONE;
          out_data_nxt.status = status_r;
          out_data_nxt.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lcpt_pkg::ST_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      base_r         <= '0;
      region_pages_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lcpt_pkg::CFG_REGION_BASE:  base_r         <= cfg_wdata;
          lcpt_pkg::CFG_REGION_PAGES: region_pages_r <= cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_cmd.valid && in_cmd.ready) begin
      mode_r <= in_cmd.data.mode;
      sp_r   <= in_cmd.data.first_page;
      cnt_r  <= in_cmd.data.num_pages;
      prot_r <= in_cmd.data.prot;
    end
    first_r    <= first_nxt;
    need_w1_r  <= need_w1_nxt;
    status_r   <= status_nxt;
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    win_r      <= win_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == lcpt_pkg::ST_CLEAR || state_r == lcpt_pkg::ST_WB0 ||
                state_r == lcpt_pkg::ST_WB1))
    else $error("bitmap written outside clear or write-back");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcpt_pkg::ST_SCAN) |-> (pos_r <= cnt_r))
    else $error("scan position beyond range");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == lcpt_pkg::KIND_RUN) |->
      (out_data_r.run_count != 6'd0 && !out_data_r.last))
    else $error("empty or final run item");

  a_wb1_after_wb0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcpt_pkg::ST_WB1) |-> ($past(state_r) == lcpt_pkg::ST_WB0 && need_w1_r))
    else $error("second word written without first");
`endif

endmodule

`default_nettype wire

[rtl/core/lcpt_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lcpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/core/lcpt_run_find.sv]
// Run finder: from the scan position, find where the current bit value ends
// inside the 32-bit window. Depends on lcpt_pkg.
`default_nettype none

module lcpt_run_find (
  input  wire logic [31:0]          win,
  input  wire logic [5:0]           pos,
  input  wire logic [5:0]           cnt,
  output lcpt_pkg::run_info_t       info
);

  logic [31:0] diff;

  always_comb begin
    info.cur = win[pos[4:0]];
    diff = (win ^ {32{info.cur}}) & ~lcpt_pkg::lt_mask(pos) & lcpt_pkg::lt_mask(cnt);
    info.end_pos = cnt;
    for (int k = 31; k >= 0; k--) begin
      if (diff[k]) begin
        info.end_pos = 6'(k);
      end
    end
    info.len = info.end_pos - pos;
    info.seg = lcpt_pkg::lt_mask(info.end_pos) & ~lcpt_pkg::lt_mask(pos);
  end

endmodule

`default_nettype wire
